>>> hw/rtl/cas_pkg.sv
`timescale 1ns / 1ps

package cas_pkg;

  // datapath format: word width and internal fraction bits
  localparam int unsigned DataW   = 32;
  localparam int unsigned FracW   = DataW - 3;
  localparam int unsigned NumIter = DataW / 2;
  localparam int unsigned IterW   = $clog2(NumIter);
  localparam int unsigned CfgW    = 5;
  localparam int unsigned AddrW   = 3;

  typedef logic signed [DataW-1:0] word_t;

  // operation select carried in tuser
  localparam logic OpAsin = 1'b0;
  localparam logic OpAcos = 1'b1;

  // register index taken from paddr[2]
  localparam logic RegInFrac  = 1'b0;
  localparam logic RegOutFrac = 1'b1;

  localparam logic [CfgW-1:0] FracC  = CfgW'(FracW);
  localparam logic [CfgW-1:0] InFracRst  = 5'd29;
  localparam logic [CfgW-1:0] OutFracRst = 5'd29;

  // 1.0 in the internal format
  localparam word_t OneQ = word_t'(1) <<< FracW;

  // state handed from cell to cell
  typedef struct packed {
    logic  op;
    word_t x;
    word_t y;
    word_t t;
    word_t theta;
  } cas_state_t;

  // twice atan(2^-i), rounded to the internal fraction bits
  function automatic word_t atan_step(logic [IterW-1:0] idx);
    word_t r;
    case (idx)
      4'd0:    r = word_t'(32'd843314856);
      4'd1:    r = word_t'(32'd497837830);
      4'd2:    r = word_t'(32'd263043836);
      4'd3:    r = word_t'(32'd133525158);
      4'd4:    r = word_t'(32'd67021686);
      4'd5:    r = word_t'(32'd33543516);
      4'd6:    r = word_t'(32'd16775850);
      4'd7:    r = word_t'(32'd8388438);
      4'd8:    r = word_t'(32'd4194282);
      4'd9:    r = word_t'(32'd2097150);
      4'd10:   r = word_t'(32'd1048576);
      4'd11:   r = word_t'(32'd524288);
      4'd12:   r = word_t'(32'd262144);
      4'd13:   r = word_t'(32'd131072);
      4'd14:   r = word_t'(32'd65536);
      4'd15:   r = word_t'(32'd32768);
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

>>> hw/rtl/cordic_arcsin_arccos_fixed_top.sv
`timescale 1ns / 1ps

// Double-iteration CORDIC arcsin/arccos. Each s_axis beat carries a 32-bit
// signed operand (tdata) and the function select in tuser (0 arcsin,
// 1 arccos); each m_axis beat returns the 32-bit signed angle in radians.
// The operand is taken with input_frac_bits fraction bits (APB address 0x0)
// and the angle is given with output_frac_bits fraction bits (address 0x4),
// both reset to 29; change them only while the block is empty. The
// datapath is a row of 16 cells, one per iteration, each two register
// slots deep, with one format stage in front and one output register
// behind: a new beat is accepted every cycle, the throughput being one
// beat per clock as long as m_axis_tready is high. Every register slot
// has its own valid bit, so bubbles are squeezed out while the output
// is stalled.
module cordic_arcsin_arccos_fixed_top (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // configuration port
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [cas_pkg::AddrW-1:0]  paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  // operand stream
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  input  logic [31:0]                s_axis_tdata,  // [31:0] operand
  input  logic                       s_axis_tuser,  // [0] op
  // angle stream
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  output logic [31:0]                m_axis_tdata   // [31:0] angle
);
  import cas_pkg::*;

  logic [CfgW-1:0] in_frac, out_frac;

  cas_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .in_frac_o  (in_frac),
    .out_frac_o (out_frac)
  );

  // cell chain links
  logic       lnk_v   [NumIter+1];
  logic       lnk_rdy [NumIter+1];
  cas_state_t lnk_d   [NumIter+1];

  // input format stage
  logic       in_vq, in_vd;
  cas_state_t in_q, in_d;
  logic       in_rdy;
  word_t      arg;

  assign in_rdy        = !in_vq || lnk_rdy[0];
  assign s_axis_tready = in_rdy;
  assign arg           = word_t'(s_axis_tdata);

  always_comb begin
    in_d.op    = s_axis_tuser;
    in_d.x     = OneQ;
    in_d.y     = '0;
    in_d.theta = '0;
    if (in_frac > FracC) begin
      in_d.t = arg >>> CfgW'(in_frac - FracC);
    end else begin
      in_d.t = arg << CfgW'(FracC - in_frac);
    end
    in_vd = in_vq;
    if (in_rdy) in_vd = s_axis_tvalid;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vq <= 1'b0;
    end else begin
      in_vq <= in_vd;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_rdy && s_axis_tvalid) begin
      in_q <= in_d;
    end
  end

  assign lnk_v[0] = in_vq;
  assign lnk_d[0] = in_q;

  // one cell per iteration
  for (genvar g = 0; g < NumIter; g++) begin : g_cell
    cas_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .idx_i   (IterW'(g)),
      .valid_i (lnk_v[g]),
      .ready_o (lnk_rdy[g]),
      .data_i  (lnk_d[g]),
      .valid_o (lnk_v[g+1]),
      .ready_i (lnk_rdy[g+1]),
      .data_o  (lnk_d[g+1])
    );
  end

  // output format stage and result register
  logic       out_vq, out_vd;
  word_t      angle_q, angle_d;
  word_t      theta;
  logic       out_rdy;

  assign out_rdy           = !out_vq || m_axis_tready;
  assign lnk_rdy[NumIter]  = out_rdy;
  assign theta             = lnk_d[NumIter].theta;

  always_comb begin
    if (out_frac > FracC) begin
      angle_d = theta << CfgW'(out_frac - FracC);
    end else begin
      angle_d = theta >>> CfgW'(FracC - out_frac);
    end
    out_vd = out_vq;
    if (out_rdy) out_vd = lnk_v[NumIter];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vq <= 1'b0;
    end else begin
      out_vq <= out_vd;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_rdy && lnk_v[NumIter]) begin
      angle_q <= angle_d;
    end
  end

  assign m_axis_tvalid = out_vq;
  assign m_axis_tdata  = angle_q;

endmodule

>>> hw/rtl/cas_cfg.sv
`timescale 1ns / 1ps

module cas_cfg (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [cas_pkg::AddrW-1:0]  paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready,
  output logic [cas_pkg::CfgW-1:0]   in_frac_o,
  output logic [cas_pkg::CfgW-1:0]   out_frac_o
);
  import cas_pkg::*;

  logic            wr_en;
  logic [CfgW-1:0] in_frac_q, in_frac_d;
  logic [CfgW-1:0] out_frac_q, out_frac_d;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  // register write decode
  always_comb begin
    in_frac_d  = in_frac_q;
    out_frac_d = out_frac_q;
    if (wr_en) begin
      case (paddr[2])
        RegInFrac:  in_frac_d  = pwdata[CfgW-1:0];
        RegOutFrac: out_frac_d = pwdata[CfgW-1:0];
        default:    ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_frac_q  <= InFracRst;
      out_frac_q <= OutFracRst;
    end else begin
      in_frac_q  <= in_frac_d;
      out_frac_q <= out_frac_d;
    end
  end

  // read back
  always_comb begin
    case (paddr[2])
      RegInFrac:  prdata = {{(32-CfgW){1'b0}}, in_frac_q};
      RegOutFrac: prdata = {{(32-CfgW){1'b0}}, out_frac_q};
      default:    prdata = '0;
    endcase
  end

  assign in_frac_o  = in_frac_q;
  assign out_frac_o = out_frac_q;

endmodule

>>> hw/rtl/cas_cell.sv
`timescale 1ns / 1ps

module cas_cell (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic [cas_pkg::IterW-1:0]  idx_i,
  input  logic                       valid_i,
  output logic                       ready_o,
  input  cas_pkg::cas_state_t        data_i,
  output logic                       valid_o,
  input  logic                       ready_i,
  output cas_pkg::cas_state_t        data_o
);
  import cas_pkg::*;

  // first half-rotation slot
  logic       a_vq, a_vd;
  logic       a_dir_q, a_dir_d;
  cas_state_t a_q, a_d;
  // second half-rotation slot
  logic       b_vq, b_vd;
  cas_state_t b_q, b_d;

  logic       a_rdy, b_rdy;
  logic       pos, cmp, dir;
  word_t      ysh, xsh, step;
  logic [IterW:0] tsh;

  assign b_rdy   = !b_vq || ready_i;
  assign a_rdy   = !a_vq || b_rdy;
  assign ready_o = a_rdy;

  // direction pick, first rotation, angle and t update
  always_comb begin
    if (data_i.op == OpAcos) begin
      pos = !data_i.y[DataW-1];
      cmp = data_i.x >= data_i.t;
    end else begin
      pos = !data_i.x[DataW-1];
      cmp = data_i.t >= data_i.y;
    end
    dir  = ~(cmp ^ pos);
    ysh  = data_i.y >>> idx_i;
    xsh  = data_i.x >>> idx_i;
    step = atan_step(idx_i);
    tsh  = {idx_i, 1'b0};

    a_d.op    = data_i.op;
    a_d.t     = data_i.t + (data_i.t >>> tsh);
    a_d.x     = dir ? data_i.x - ysh : data_i.x + ysh;
    a_d.y     = dir ? data_i.y + xsh : data_i.y - xsh;
    a_d.theta = dir ? data_i.theta + step : data_i.theta - step;
    a_dir_d   = dir;
  end

  // second rotation
  always_comb begin
    b_d = a_q;
    if (a_dir_q) begin
      b_d.x = a_q.x - (a_q.y >>> idx_i);
      b_d.y = a_q.y + (a_q.x >>> idx_i);
    end else begin
      b_d.x = a_q.x + (a_q.y >>> idx_i);
      b_d.y = a_q.y - (a_q.x >>> idx_i);
    end
  end

  // slot occupancy
  always_comb begin
    a_vd = a_vq;
    if (a_rdy) a_vd = valid_i;
    b_vd = b_vq;
    if (b_rdy) b_vd = a_vq;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vq <= 1'b0;
      b_vq <= 1'b0;
    end else begin
      a_vq <= a_vd;
      b_vq <= b_vd;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_rdy && valid_i) begin
      a_q     <= a_d;
      a_dir_q <= a_dir_d;
    end
    if (b_rdy && a_vq) begin
      b_q <= b_d;
    end
  end

  assign valid_o = b_vq;
  assign data_o  = b_q;

  // a beat taken into the cell lands in the first slot
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_i && ready_o |=> a_vq)
    else $error("cas_cell: accepted beat lost in first slot");

  // first slot holds while the second slot cannot take it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    a_vq && !b_rdy |=> a_vq && $stable(a_q) && $stable(a_dir_q))
    else $error("cas_cell: first slot changed while blocked");

  // second slot holds while downstream stalls
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    b_vq && !ready_i |=> b_vq && $stable(b_q))
    else $error("cas_cell: second slot changed while stalled");

endmodule
